// File: design/assert_macros.svh
// Assertion helpers shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// File: design/btffa_pkg.sv
package btffa_pkg;

   localparam int ARENA_GRANULES_DEF = 4096;
   localparam int GRANULE_BYTES_DEF  = 64;
   localparam int ADDR_W             = 18;
   localparam int BYTES_W            = 32;
   localparam int REQ_DATA_W         = 56;
   localparam int RSP_DATA_W         = 24;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [4:0] {
      S_INIT0, S_INIT1, S_IDLE,
      S_WALK_RD, S_WALK_CHK,
      S_UNL1, S_UNL2,
      S_SPLIT1, S_SPLIT2,
      S_PUSH1, S_PUSH2,
      S_MARK, S_FAIL,
      S_F_START, S_F_SIZE, S_F_CHKN, S_F_RDP, S_F_CHKP, S_F_BACK, S_F_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_INIT0, CMD_INIT1, CMD_ACCEPT,
      CMD_WALK_RD, CMD_WALK_NEXT, CMD_TAKE,
      CMD_UNL1, CMD_UNL2, CMD_SPLIT1, CMD_SPLIT2,
      CMD_PUSH1, CMD_PUSH2, CMD_MARK, CMD_FAIL,
      CMD_F_START, CMD_F_SIZE, CMD_F_MERGE_N, CMD_F_RD_P, CMD_F_MERGE_P,
      CMD_F_BACK, CMD_DONE_FREE
   } cmd_type;

   typedef struct packed {
      logic rsp_full;
      logic is_free;
      logic free_bad;
      logic cur_none;
      logic steps_out;
      logic fits;
      logic rd_next_in;
      logic rd_free;
      logic prev_ok;
      logic split_ok;
   } status_type;

endpackage

// File: design/btffa_ctrl.sv
`include "assert_macros.svh"

module btffa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  btffa_pkg::status_type  status,
   output btffa_pkg::cmd_type     cmd
);

   btffa_pkg::state_type state_ff, state_in;
   btffa_pkg::state_type ret_ff, ret_in;

   // State and return registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btffa_pkg::S_INIT0;
         ret_ff   <= btffa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   assign req_tready = (state_ff == btffa_pkg::S_IDLE);

   // Sequence the request through the datapath
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = btffa_pkg::CMD_NONE;
      case (state_ff)
         btffa_pkg::S_INIT0: begin
            cmd      = btffa_pkg::CMD_INIT0;
            state_in = btffa_pkg::S_INIT1;
         end
         btffa_pkg::S_INIT1: begin
            cmd      = btffa_pkg::CMD_INIT1;
            state_in = btffa_pkg::S_IDLE;
         end
         btffa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd = btffa_pkg::CMD_ACCEPT;
               state_in = btffa_pkg::S_WALK_RD;
            end
         end
         btffa_pkg::S_WALK_RD: begin
            if (status.is_free) begin
               state_in = status.free_bad ? btffa_pkg::S_F_DONE : btffa_pkg::S_F_START;
            end else if (status.cur_none || status.steps_out) begin
               state_in = btffa_pkg::S_FAIL;
            end else begin
               cmd      = btffa_pkg::CMD_WALK_RD;
               state_in = btffa_pkg::S_WALK_CHK;
            end
         end
         btffa_pkg::S_WALK_CHK: begin
            if (status.fits) begin
               cmd      = btffa_pkg::CMD_TAKE;
               ret_in   = btffa_pkg::S_SPLIT1;
               state_in = btffa_pkg::S_UNL1;
            end else begin
               cmd      = btffa_pkg::CMD_WALK_NEXT;
               state_in = btffa_pkg::S_WALK_RD;
            end
         end
         btffa_pkg::S_UNL1: begin
            cmd      = btffa_pkg::CMD_UNL1;
            state_in = btffa_pkg::S_UNL2;
         end
         btffa_pkg::S_UNL2: begin
            cmd      = btffa_pkg::CMD_UNL2;
            state_in = ret_ff;
         end
         btffa_pkg::S_SPLIT1: begin
            if (status.split_ok) begin
               cmd      = btffa_pkg::CMD_SPLIT1;
               state_in = btffa_pkg::S_SPLIT2;
            end else begin
               state_in = btffa_pkg::S_MARK;
            end
         end
         btffa_pkg::S_SPLIT2: begin
            cmd      = btffa_pkg::CMD_SPLIT2;
            state_in = btffa_pkg::S_PUSH1;
         end
         btffa_pkg::S_PUSH1: begin
            cmd      = btffa_pkg::CMD_PUSH1;
            state_in = btffa_pkg::S_PUSH2;
         end
         btffa_pkg::S_PUSH2: begin
            cmd      = btffa_pkg::CMD_PUSH2;
            state_in = status.is_free ? btffa_pkg::S_F_DONE : btffa_pkg::S_MARK;
         end
         btffa_pkg::S_MARK: begin
            if (!status.rsp_full) begin
               cmd      = btffa_pkg::CMD_MARK;
               state_in = btffa_pkg::S_IDLE;
            end
         end
         btffa_pkg::S_FAIL: begin
            if (!status.rsp_full) begin
               cmd      = btffa_pkg::CMD_FAIL;
               state_in = btffa_pkg::S_IDLE;
            end
         end
         btffa_pkg::S_F_START: begin
            cmd      = btffa_pkg::CMD_F_START;
            state_in = btffa_pkg::S_F_SIZE;
         end
         btffa_pkg::S_F_SIZE: begin
            cmd      = btffa_pkg::CMD_F_SIZE;
            state_in = status.rd_next_in ? btffa_pkg::S_F_CHKN : btffa_pkg::S_F_RDP;
         end
         btffa_pkg::S_F_CHKN: begin
            if (status.rd_free) begin
               cmd      = btffa_pkg::CMD_F_MERGE_N;
               ret_in   = btffa_pkg::S_F_RDP;
               state_in = btffa_pkg::S_UNL1;
            end else begin
               state_in = btffa_pkg::S_F_RDP;
            end
         end
         btffa_pkg::S_F_RDP: begin
            if (status.prev_ok) begin
               cmd      = btffa_pkg::CMD_F_RD_P;
               state_in = btffa_pkg::S_F_CHKP;
            end else begin
               state_in = btffa_pkg::S_F_BACK;
            end
         end
         btffa_pkg::S_F_CHKP: begin
            if (status.rd_free) begin
               cmd      = btffa_pkg::CMD_F_MERGE_P;
               ret_in   = btffa_pkg::S_F_BACK;
               state_in = btffa_pkg::S_UNL1;
            end else begin
               state_in = btffa_pkg::S_F_BACK;
            end
         end
         btffa_pkg::S_F_BACK: begin
            cmd      = btffa_pkg::CMD_F_BACK;
            state_in = btffa_pkg::S_PUSH1;
         end
         btffa_pkg::S_F_DONE: begin
            if (!status.rsp_full) begin
               cmd      = btffa_pkg::CMD_DONE_FREE;
               state_in = btffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = btffa_pkg::S_IDLE;
         end
      endcase
   end

   // A result is only loaded into an empty output register
   `ASSERT_IMPL(a_emit_empty, (cmd == btffa_pkg::CMD_MARK || cmd == btffa_pkg::CMD_FAIL || cmd == btffa_pkg::CMD_DONE_FREE), !status.rsp_full, "result loaded over a pending one")
   // The walk only reads with a live cursor
   `ASSERT_IMPL(a_walk_live, cmd == btffa_pkg::CMD_WALK_RD, !status.cur_none && !status.steps_out, "walk read past end of list")

endmodule

// File: design/btffa_datapath.sv
`include "assert_macros.svh"

module btffa_datapath #(
   parameter int ARENA_GRANULES = btffa_pkg::ARENA_GRANULES_DEF,
   parameter int GRANULE_BYTES  = btffa_pkg::GRANULE_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [btffa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,
   input  btffa_pkg::cmd_type                cmd,
   output btffa_pkg::status_type             status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [btffa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int LW  = $clog2(ARENA_GRANULES + 1);
   localparam int LW1 = LW + 1;
   localparam int IW  = $clog2(ARENA_GRANULES);
   localparam int GS  = $clog2(GRANULE_BYTES);
   localparam int NW  = btffa_pkg::BYTES_W + 2 - GS;
   localparam int NW1 = NW + 1;
   localparam int AW  = btffa_pkg::ADDR_W;
   localparam int GW  = AW - GS;
   localparam logic [LW-1:0] NONE = LW'(ARENA_GRANULES);
   localparam logic [LW-1:0] LAST = LW'(ARENA_GRANULES - 1);

   // Header stores, one entry per granule
   logic [LW-1:0] size_mem [ARENA_GRANULES];
   logic          busy_mem [ARENA_GRANULES];
   logic [LW-1:0] back_mem [ARENA_GRANULES];
   logic [LW-1:0] next_mem [ARENA_GRANULES];
   logic [LW-1:0] prev_mem [ARENA_GRANULES];

   logic          size_we, busy_we, back_we, next_we, prev_we;
   logic [IW-1:0] size_wa, busy_wa, back_wa, next_wa, prev_wa;
   logic [LW-1:0] size_wd, back_wd, next_wd, prev_wd;
   logic          busy_wd;
   logic          rd_en;
   logic [IW-1:0] rd_idx;

   logic [LW-1:0] rd_size_ff, rd_back_ff, rd_next_ff, rd_prev_ff;
   logic          rd_busy_ff;

   logic          op_ff, op_in;
   logic          free_bad_ff, free_bad_in;
   logic [NW-1:0] need_ff, need_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] sz_ff, sz_in;
   logic [LW-1:0] back_ff, back_in;
   logic [LW-1:0] u_node_ff, u_node_in, u_prev_ff, u_prev_in, u_next_ff, u_next_in;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [LW-1:0] head_ff, head_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;

   // Request decode
   logic [btffa_pkg::BYTES_W-1:0] req_bytes, bytes1;
   logic [AW-1:0]                 req_addr;
   logic [btffa_pkg::BYTES_W:0]   round_sum;
   logic [NW-1:0]                 need_calc;
   logic [GW-1:0]                 g_calc;
   logic                          bad_calc;
   logic [LW-1:0]                 c_calc;

   assign req_bytes = req_tdata[btffa_pkg::BYTES_W-1:0];
   assign req_addr  = req_tdata[btffa_pkg::BYTES_W +: AW];
   assign bytes1    = (req_bytes == '0) ? btffa_pkg::BYTES_W'(1) : req_bytes;
   assign round_sum = (btffa_pkg::BYTES_W+1)'(bytes1)
                    + (btffa_pkg::BYTES_W+1)'(GRANULE_BYTES - 1);
   assign need_calc = NW'(round_sum >> GS) + NW'(1);
   assign g_calc    = req_addr[AW-1:GS];
   assign bad_calc  = (req_addr == '0) || (g_calc == '0)
                    || (32'(g_calc) > 32'(ARENA_GRANULES));
   assign c_calc    = LW'(32'(g_calc) - 32'd1);

   // Derived addresses
   logic [LW:0]   cur_plus_sz, cur_plus_rd, cur_p1;
   logic [LW-1:0] p_idx, size_sum_n, size_sum_p;
   logic [NW-1:0] rest_w;
   logic [NW:0]   r_w;
   logic          after_in;

   assign cur_plus_sz = LW1'(cur_ff) + LW1'(sz_ff);
   assign cur_plus_rd = LW1'(cur_ff) + LW1'(rd_size_ff);
   assign cur_p1      = LW1'(cur_ff) + LW1'(1);
   assign p_idx       = cur_ff - back_ff;
   assign size_sum_n  = sz_ff + rd_size_ff;
   assign size_sum_p  = rd_size_ff + sz_ff;
   assign rest_w      = NW'(sz_ff) - need_ff;
   assign r_w         = NW1'(cur_ff) + NW1'(need_ff);
   assign after_in    = cur_plus_sz < LW1'(ARENA_GRANULES);

   // Status toward the controller
   always_comb begin
      status.rsp_full   = rsp_valid_ff;
      status.is_free    = op_ff;
      status.free_bad   = free_bad_ff;
      status.cur_none   = cur_ff >= NONE;
      status.steps_out  = steps_ff >= NONE;
      status.fits       = NW'(rd_size_ff) >= need_ff;
      status.rd_next_in = cur_plus_rd < LW1'(ARENA_GRANULES);
      status.rd_free    = !rd_busy_ff;
      status.prev_ok    = (back_ff != '0) && (back_ff <= cur_ff);
      status.split_ok   = (rest_w >= NW'(2)) && (r_w < NW1'(ARENA_GRANULES));
   end

   // Decode commands into store writes and register updates
   always_comb begin
      size_we = 1'b0; size_wa = '0; size_wd = '0;
      busy_we = 1'b0; busy_wa = '0; busy_wd = 1'b0;
      back_we = 1'b0; back_wa = '0; back_wd = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0;
      prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
      rd_en = 1'b0; rd_idx = cur_ff[IW-1:0];
      op_in = op_ff; free_bad_in = free_bad_ff; need_in = need_ff;
      steps_in = steps_ff; cur_in = cur_ff; sz_in = sz_ff; back_in = back_ff;
      u_node_in = u_node_ff; u_prev_in = u_prev_ff; u_next_in = u_next_ff;
      tgt_in = tgt_ff; head_in = head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in = rsp_ok_ff; rsp_addr_in = rsp_addr_ff;
      case (cmd)
         btffa_pkg::CMD_INIT0: begin
            size_we = 1'b1; size_wa = '0; size_wd = LAST;
            busy_we = 1'b1; busy_wa = '0; busy_wd = 1'b0;
            back_we = 1'b1; back_wa = '0; back_wd = '0;
            next_we = 1'b1; next_wa = '0; next_wd = NONE;
            prev_we = 1'b1; prev_wa = '0; prev_wd = NONE;
         end
         btffa_pkg::CMD_INIT1: begin
            size_we = 1'b1; size_wa = LAST[IW-1:0]; size_wd = LW'(1);
            busy_we = 1'b1; busy_wa = LAST[IW-1:0]; busy_wd = 1'b1;
            back_we = 1'b1; back_wa = LAST[IW-1:0]; back_wd = LAST;
         end
         btffa_pkg::CMD_ACCEPT: begin
            op_in       = req_tuser;
            free_bad_in = bad_calc;
            need_in     = need_calc;
            steps_in    = '0;
            cur_in      = (req_tuser == btffa_pkg::OP_FREE) ? c_calc : head_ff;
         end
         btffa_pkg::CMD_WALK_RD: begin
            rd_en = 1'b1;
         end
         btffa_pkg::CMD_WALK_NEXT: begin
            cur_in   = rd_next_ff;
            steps_in = steps_ff + LW'(1);
         end
         btffa_pkg::CMD_TAKE: begin
            u_node_in = cur_ff;
            u_prev_in = rd_prev_ff;
            u_next_in = rd_next_ff;
            sz_in     = rd_size_ff;
         end
         btffa_pkg::CMD_UNL1: begin
            if (u_prev_ff < NONE) begin
               next_we = 1'b1; next_wa = u_prev_ff[IW-1:0]; next_wd = u_next_ff;
            end else begin
               head_in = u_next_ff;
            end
            if (u_next_ff < NONE) begin
               prev_we = 1'b1; prev_wa = u_next_ff[IW-1:0]; prev_wd = u_prev_ff;
            end
         end
         btffa_pkg::CMD_UNL2: begin
            next_we = 1'b1; next_wa = u_node_ff[IW-1:0]; next_wd = NONE;
            prev_we = 1'b1; prev_wa = u_node_ff[IW-1:0]; prev_wd = NONE;
         end
         btffa_pkg::CMD_SPLIT1: begin
            size_we = 1'b1; size_wa = r_w[IW-1:0]; size_wd = LW'(rest_w);
            busy_we = 1'b1; busy_wa = r_w[IW-1:0]; busy_wd = 1'b0;
            back_we = 1'b1; back_wa = r_w[IW-1:0]; back_wd = LW'(need_ff);
         end
         btffa_pkg::CMD_SPLIT2: begin
            if (after_in) begin
               back_we = 1'b1; back_wa = cur_plus_sz[IW-1:0]; back_wd = LW'(rest_w);
            end
            size_we = 1'b1; size_wa = cur_ff[IW-1:0]; size_wd = LW'(need_ff);
            tgt_in  = LW'(r_w);
         end
         btffa_pkg::CMD_PUSH1: begin
            prev_we = 1'b1; prev_wa = tgt_ff[IW-1:0]; prev_wd = NONE;
            next_we = 1'b1; next_wa = tgt_ff[IW-1:0]; next_wd = head_ff;
         end
         btffa_pkg::CMD_PUSH2: begin
            if (head_ff < NONE) begin
               prev_we = 1'b1; prev_wa = head_ff[IW-1:0]; prev_wd = tgt_ff;
            end
            head_in = tgt_ff;
         end
         btffa_pkg::CMD_MARK: begin
            busy_we = 1'b1; busy_wa = cur_ff[IW-1:0]; busy_wd = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_addr_in  = AW'(32'(cur_p1) << GS);
         end
         btffa_pkg::CMD_FAIL: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b0;
            rsp_addr_in  = '0;
         end
         btffa_pkg::CMD_F_START: begin
            busy_we = 1'b1; busy_wa = cur_ff[IW-1:0]; busy_wd = 1'b0;
            rd_en   = 1'b1;
         end
         btffa_pkg::CMD_F_SIZE: begin
            sz_in   = rd_size_ff;
            back_in = rd_back_ff;
            rd_en   = 1'b1;
            rd_idx  = cur_plus_rd[IW-1:0];
         end
         btffa_pkg::CMD_F_MERGE_N: begin
            u_node_in = LW'(cur_plus_sz);
            u_prev_in = rd_prev_ff;
            u_next_in = rd_next_ff;
            sz_in     = size_sum_n;
            size_we = 1'b1; size_wa = cur_ff[IW-1:0]; size_wd = size_sum_n;
         end
         btffa_pkg::CMD_F_RD_P: begin
            rd_en  = 1'b1;
            rd_idx = p_idx[IW-1:0];
         end
         btffa_pkg::CMD_F_MERGE_P: begin
            u_node_in = p_idx;
            u_prev_in = rd_prev_ff;
            u_next_in = rd_next_ff;
            sz_in     = size_sum_p;
            cur_in    = p_idx;
            size_we = 1'b1; size_wa = p_idx[IW-1:0]; size_wd = size_sum_p;
         end
         btffa_pkg::CMD_F_BACK: begin
            if (after_in) begin
               back_we = 1'b1; back_wa = cur_plus_sz[IW-1:0]; back_wd = sz_ff;
            end
            tgt_in = cur_ff;
         end
         btffa_pkg::CMD_DONE_FREE: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_addr_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Header stores: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (size_we) size_mem[size_wa] <= size_wd;
      if (busy_we) busy_mem[busy_wa] <= busy_wd;
      if (back_we) back_mem[back_wa] <= back_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (rd_en) begin
         rd_size_ff <= size_mem[rd_idx];
         rd_busy_ff <= busy_mem[rd_idx];
         rd_back_ff <= back_mem[rd_idx];
         rd_next_ff <= next_mem[rd_idx];
         rd_prev_ff <= prev_mem[rd_idx];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= btffa_pkg::OP_ALLOC;
         steps_ff     <= '0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         steps_ff     <= steps_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      free_bad_ff <= free_bad_in;
      need_ff     <= need_in;
      cur_ff      <= cur_in;
      sz_ff       <= sz_in;
      back_ff     <= back_in;
      u_node_ff   <= u_node_in;
      u_prev_ff   <= u_prev_in;
      u_next_ff   <= u_next_in;
      tgt_ff      <= tgt_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = btffa_pkg::RSP_DATA_W'({rsp_ok_ff, rsp_addr_ff});

   // A failed allocation never carries an address
   `ASSERT_IMPL(a_fail_zero, rsp_valid_ff && !rsp_ok_ff, rsp_addr_ff == '0, "failure with nonzero address")
   // The walk counter never passes the arena size
   `ASSERT_CLK(a_steps_bound, steps_ff <= NONE, "walk counter overran")
   // A granted address is always granule aligned and nonzero
   `ASSERT_IMPL(a_grant_addr, cmd == btffa_pkg::CMD_MARK, rsp_addr_in[GS-1:0] == '0, "misaligned grant")

endmodule

// File: design/boundary_tag_first_fit_allocator.sv
// First-fit boundary-tag allocator over an arena of ARENA_GRANULES granules of
// GRANULE_BYTES bytes. Send a request with req_tuser = 0 to allocate
// req_tdata[31:0] bytes, or req_tuser = 1 to free the payload address in
// req_tdata[49:32]; one response comes back for every request, carrying the
// payload address (0 on failure and on free) and an ok flag. One request is
// handled at a time. After reset the block writes the initial arena headers
// before it raises req_tready. Header stores have one read and one write
// port each. An allocate walks the free list and hands out the first chunk
// that fits, whole or split, and fails when the list runs out. A free of a
// bad address is ignored; any other free merges the chunk with a free next
// neighbor in the arena and with a free previous neighbor. The response load
// waits while the previous response is still held in the output register,
// but a new request is taken while that response waits.
module boundary_tag_first_fit_allocator #(
   parameter int ARENA_GRANULES = btffa_pkg::ARENA_GRANULES_DEF,
   parameter int GRANULE_BYTES  = btffa_pkg::GRANULE_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] request_bytes, [49:32] release_address, [55:50] zero
   input  logic [btffa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [17:0] payload_address, [18] ok, [23:19] zero
   output logic [btffa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   btffa_pkg::cmd_type    cmd;
   btffa_pkg::status_type status;

   btffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   btffa_datapath #(
      .ARENA_GRANULES (ARENA_GRANULES),
      .GRANULE_BYTES  (GRANULE_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
